### src/taqe_pkg.sv
package taqe_pkg;

  localparam int MAX_NODES = 1023;
  localparam int LEVELS    = 11;
  localparam int NODE_W    = 10;
  localparam int DEPTH_W   = 10;
  localparam int DIST_W    = 11;
  localparam int STEP_W    = 10;
  localparam int CMD_W     = 3;
  localparam int MEM_ROWS  = MAX_NODES + 1;
  localparam int ADDR_W    = $clog2(MEM_ROWS);
  localparam int LV_W      = $clog2(LEVELS);

  localparam logic [LV_W-1:0] LV_TOP = LV_W'(LEVELS - 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD = 3'd0,
    CMD_LCA  = 3'd1,
    CMD_KTH  = 3'd2,
    CMD_DIST = 3'd3,
    CMD_PATH = 3'd4
  } cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [STEP_W-1:0] step_count;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] result_node;
    logic [DIST_W-1:0] result_distance;
    logic              step_out_of_range;
  } out_item_t;

  // one memory row per node: depth and the ancestor chain
  typedef struct packed {
    logic [DEPTH_W-1:0]             depth;
    logic [LEVELS-1:0][NODE_W-1:0] anc;
  } row_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_CAPTURE,
    OP_DISPATCH,
    OP_LD_STEP,
    OP_LD_WRITE,
    OP_M_INIT,
    OP_M_UP,
    OP_M_CHK,
    OP_M_DN,
    OP_P_DL,
    OP_C_INIT,
    OP_C_STEP,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t          op;
    logic [LV_W-1:0] lv;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic load_ok;
    logic uv_equal;
    logic to_climb;
    logic climb_abort;
    logic clear_last;
  } dp_stat_t;

endpackage

### src/taqe_ctrl.sv
module taqe_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                out_stall,
  output logic                out_valid,
  input  taqe_pkg::dp_stat_t  stat,
  output taqe_pkg::ctrl_cmd_t cmd
);
  import taqe_pkg::*;

  typedef enum logic [12:0] {
    ST_IDLE     = 13'b0000000000001,
    ST_CLEAR    = 13'b0000000000010,
    ST_DISPATCH = 13'b0000000000100,
    ST_L_STEP   = 13'b0000000001000,
    ST_L_WR     = 13'b0000000010000,
    ST_M_INIT   = 13'b0000000100000,
    ST_M_UP     = 13'b0000001000000,
    ST_M_CHK    = 13'b0000010000000,
    ST_M_DN     = 13'b0000100000000,
    ST_P_DL     = 13'b0001000000000,
    ST_C_INIT   = 13'b0010000000000,
    ST_C_STEP   = 13'b0100000000000,
    ST_FIN      = 13'b1000000000000
  } state_t;

  state_t          state_r, state_nxt;
  logic [LV_W-1:0] lv_r, lv_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            emit;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign emit      = (state_r == ST_FIN) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    lv_nxt    = lv_r;
    cmd.op    = OP_NONE;
    cmd.lv    = lv_r;
    case (state_r)
      ST_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (stat.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_CAPTURE;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cmd.op = OP_DISPATCH;
        case (stat.cmd)
          CMD_LOAD: begin
            lv_nxt    = LV_W'(1);
            state_nxt = stat.load_ok ? ST_L_STEP : ST_FIN;
          end
          CMD_LCA, CMD_DIST, CMD_PATH: state_nxt = ST_M_INIT;
          CMD_KTH: state_nxt = ST_C_INIT;
          default: state_nxt = ST_FIN;
        endcase
      end
      ST_L_STEP: begin
        cmd.op = OP_LD_STEP;
        if (lv_r == LV_TOP) state_nxt = ST_L_WR;
        else lv_nxt = lv_r + 1'b1;
      end
      ST_L_WR: begin
        cmd.op    = OP_LD_WRITE;
        state_nxt = ST_FIN;
      end
      ST_M_INIT: begin
        cmd.op    = OP_M_INIT;
        lv_nxt    = LV_TOP;
        state_nxt = ST_M_UP;
      end
      ST_M_UP: begin
        cmd.op = OP_M_UP;
        if (lv_r == '0) state_nxt = ST_M_CHK;
        else lv_nxt = lv_r - 1'b1;
      end
      ST_M_CHK: begin
        cmd.op = OP_M_CHK;
        lv_nxt = LV_TOP;
        state_nxt = stat.uv_equal ? ST_P_DL : ST_M_DN;
      end
      ST_M_DN: begin
        cmd.op = OP_M_DN;
        if (lv_r == '0) state_nxt = ST_P_DL;
        else lv_nxt = lv_r - 1'b1;
      end
      ST_P_DL: begin
        cmd.op    = OP_P_DL;
        state_nxt = stat.to_climb ? ST_C_INIT : ST_FIN;
      end
      ST_C_INIT: begin
        cmd.op    = OP_C_INIT;
        lv_nxt    = '0;
        state_nxt = stat.climb_abort ? ST_FIN : ST_C_STEP;
      end
      ST_C_STEP: begin
        cmd.op = OP_C_STEP;
        if (lv_r == LV_TOP) state_nxt = ST_FIN;
        else lv_nxt = lv_r + 1'b1;
      end
      ST_FIN: begin
        if (emit) begin
          cmd.op    = OP_EMIT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (emit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      lv_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lv_r        <= lv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### src/taqe_dp.sv
module taqe_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  taqe_pkg::in_item_t  in_data,
  output taqe_pkg::out_item_t out_data,
  input  taqe_pkg::ctrl_cmd_t cmd,
  output taqe_pkg::dp_stat_t  stat
);
  import taqe_pkg::*;

  row_t mem [MEM_ROWS];

  row_t              rdata0_r, rdata1_r;
  logic [ADDR_W-1:0] raddr0, raddr1, waddr;
  row_t              wdata;
  logic              we;

  logic [ADDR_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [NODE_W-1:0]  a_r, a_nxt, b_r, b_nxt;
  logic [STEP_W-1:0]  k_r, k_nxt;
  logic [NODE_W-1:0]  u_r, u_nxt, v_r, v_nxt, l_r, l_nxt;
  logic [NODE_W-1:0]  cand_r, cand_nxt, cand2_r, cand2_nxt;
  row_t               row_u_r, row_u_nxt, row_v_r, row_v_nxt;
  logic [DEPTH_W-1:0] dv_r, dv_nxt, da_r, da_nxt, db_r, db_nxt;
  logic [DIST_W-1:0]  kc_r, kc_nxt;
  logic [NODE_W-1:0]  res_node_r, res_node_nxt;
  logic [DIST_W-1:0]  res_dist_r, res_dist_nxt;
  logic               res_flag_r, res_flag_nxt;
  out_item_t          out_r, out_nxt;

  // path arithmetic, used once the meeting node's depth is read
  logic [DEPTH_W-1:0]      dl;
  logic signed [DIST_W:0]  d_raw;
  logic [DIST_W-1:0]       d_sat;
  logic [DIST_W-1:0]       kz;
  logic                    k_ge_d;
  logic                    near_side;
  logic [DEPTH_W:0]        dinc;
  logic [NODE_W-1:0]       ld_anc;
  logic                    swap;
  logic [NODE_W-1:0]       nu, nv;
  row_t                    nru, nrv;

  assign dl        = rdata0_r.depth;
  assign d_raw     = $signed({2'b00, da_r}) + $signed({2'b00, db_r})
                   - $signed({1'b0, dl, 1'b0});
  assign d_sat     = d_raw[DIST_W] ? '0 : d_raw[DIST_W-1:0];
  assign kz        = {1'b0, k_r};
  assign k_ge_d    = (kz >= d_sat);
  assign near_side = (({1'b0, dl} + {1'b0, k_r}) <= {1'b0, da_r});
  assign dinc      = {1'b0, rdata0_r.depth} + 1'b1;
  assign ld_anc    = (cand_r == a_r) ? a_r : rdata0_r.anc[LV_W'(cmd.lv - 1'b1)];
  assign swap      = (rdata0_r.depth < rdata1_r.depth);

  assign stat.cmd         = cmd_r;
  assign stat.load_ok     = (a_r != '0);
  assign stat.uv_equal    = (u_r == v_r);
  assign stat.to_climb    = (cmd_r == CMD_PATH) && !k_ge_d;
  assign stat.climb_abort = (kc_r > {1'b0, rdata0_r.depth});
  assign stat.clear_last  = (clr_cnt_r == ADDR_W'(MAX_NODES));

  assign out_data = out_r;

  always_comb begin
    clr_cnt_nxt  = clr_cnt_r;
    cmd_nxt      = cmd_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    k_nxt        = k_r;
    u_nxt        = u_r;
    v_nxt        = v_r;
    l_nxt        = l_r;
    cand_nxt     = cand_r;
    cand2_nxt    = cand2_r;
    row_u_nxt    = row_u_r;
    row_v_nxt    = row_v_r;
    dv_nxt       = dv_r;
    da_nxt       = da_r;
    db_nxt       = db_r;
    kc_nxt       = kc_r;
    res_node_nxt = res_node_r;
    res_dist_nxt = res_dist_r;
    res_flag_nxt = res_flag_r;
    out_nxt      = out_r;
    raddr0       = '0;
    raddr1       = '0;
    waddr        = '0;
    wdata        = '0;
    we           = 1'b0;
    nu           = u_r;
    nv           = v_r;
    nru          = row_u_r;
    nrv          = row_v_r;
    case (cmd.op)
      OP_CLEAR: begin
        we          = 1'b1;
        waddr       = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
      OP_CAPTURE: begin
        cmd_nxt = cmd_t'(in_data.cmd);
        a_nxt   = in_data.node_a;
        b_nxt   = in_data.node_b;
        k_nxt   = in_data.step_count;
      end
      OP_DISPATCH: begin
        res_node_nxt = '0;
        res_dist_nxt = '0;
        res_flag_nxt = 1'b0;
        case (cmd_r)
          CMD_LOAD: begin
            res_node_nxt  = a_r;
            row_u_nxt     = '0;
            row_u_nxt.anc[0] = b_r;
            cand_nxt      = b_r;
            raddr0        = b_r;
          end
          CMD_KTH: begin
            cand_nxt = a_r;
            kc_nxt   = kz;
            raddr0   = a_r;
          end
          CMD_LCA, CMD_DIST, CMD_PATH: begin
            raddr0 = a_r;
            raddr1 = b_r;
          end
          default: ;
        endcase
      end
      OP_LD_STEP: begin
        // a chain that runs back into the node itself sees its new entries
        if (cmd.lv == LV_W'(1)) begin
          row_u_nxt.depth = (dinc > (DEPTH_W+1)'(MAX_NODES)) ?
                            DEPTH_W'(MAX_NODES) : dinc[DEPTH_W-1:0];
        end
        row_u_nxt.anc[cmd.lv] = ld_anc;
        cand_nxt = ld_anc;
        raddr0   = ld_anc;
      end
      OP_LD_WRITE: begin
        we    = 1'b1;
        waddr = a_r;
        wdata = row_u_r;
      end
      OP_M_INIT: begin
        da_nxt = rdata0_r.depth;
        db_nxt = rdata1_r.depth;
        if (swap) begin
          u_nxt = b_r; row_u_nxt = rdata1_r;
          v_nxt = a_r; row_v_nxt = rdata0_r; dv_nxt = rdata0_r.depth;
          cand_nxt = rdata1_r.anc[LV_TOP];
        end else begin
          u_nxt = a_r; row_u_nxt = rdata0_r;
          v_nxt = b_r; row_v_nxt = rdata1_r; dv_nxt = rdata1_r.depth;
          cand_nxt = rdata0_r.anc[LV_TOP];
        end
        raddr0 = cand_nxt;
      end
      OP_M_UP: begin
        if (rdata0_r.depth >= dv_r) begin
          nu  = cand_r;
          nru = rdata0_r;
        end
        u_nxt     = nu;
        row_u_nxt = nru;
        if (cmd.lv != '0) begin
          cand_nxt = nru.anc[LV_W'(cmd.lv - 1'b1)];
          raddr0   = cand_nxt;
        end
      end
      OP_M_CHK: begin
        if (u_r == v_r) begin
          l_nxt  = v_r;
          raddr0 = v_r;
        end else begin
          cand_nxt  = row_u_r.anc[LV_TOP];
          cand2_nxt = row_v_r.anc[LV_TOP];
          raddr0    = cand_nxt;
          raddr1    = cand2_nxt;
        end
      end
      OP_M_DN: begin
        if (cand_r != cand2_r) begin
          nu  = cand_r;
          nv  = cand2_r;
          nru = rdata0_r;
          nrv = rdata1_r;
        end
        u_nxt     = nu;
        v_nxt     = nv;
        row_u_nxt = nru;
        row_v_nxt = nrv;
        if (cmd.lv == '0) begin
          l_nxt  = nru.anc[0];
          raddr0 = l_nxt;
        end else begin
          cand_nxt  = nru.anc[LV_W'(cmd.lv - 1'b1)];
          cand2_nxt = nrv.anc[LV_W'(cmd.lv - 1'b1)];
          raddr0    = cand_nxt;
          raddr1    = cand2_nxt;
        end
      end
      OP_P_DL: begin
        case (cmd_r)
          CMD_LCA:  res_node_nxt = l_r;
          CMD_DIST: res_dist_nxt = d_sat;
          CMD_PATH: begin
            if (k_ge_d) begin
              res_flag_nxt = 1'b1;
            end else if (near_side) begin
              cand_nxt = a_r;
              kc_nxt   = kz;
              raddr0   = a_r;
            end else begin
              // remaining climb from b is the distance minus the step
              cand_nxt = b_r;
              kc_nxt   = d_sat - kz;
              raddr0   = b_r;
            end
          end
          default: ;
        endcase
      end
      OP_C_INIT: begin
        if (!(kc_r > {1'b0, rdata0_r.depth})) begin
          u_nxt     = cand_r;
          row_u_nxt = rdata0_r;
          cand_nxt  = rdata0_r.anc[0];
          raddr0    = cand_nxt;
        end
      end
      OP_C_STEP: begin
        if (kc_r[cmd.lv]) begin
          nu  = cand_r;
          nru = rdata0_r;
        end
        u_nxt     = nu;
        row_u_nxt = nru;
        if (cmd.lv == LV_TOP) begin
          res_node_nxt = nu;
        end else begin
          cand_nxt = nru.anc[LV_W'(cmd.lv + 1'b1)];
          raddr0   = cand_nxt;
        end
      end
      OP_EMIT: begin
        out_nxt.result_node       = res_node_r;
        out_nxt.result_distance   = res_dist_r;
        out_nxt.step_out_of_range = res_flag_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata0_r <= mem[raddr0];
    rdata1_r <= mem[raddr1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    k_r        <= k_nxt;
    u_r        <= u_nxt;
    v_r        <= v_nxt;
    l_r        <= l_nxt;
    cand_r     <= cand_nxt;
    cand2_r    <= cand2_nxt;
    row_u_r    <= row_u_nxt;
    row_v_r    <= row_v_nxt;
    dv_r       <= dv_nxt;
    da_r       <= da_nxt;
    db_r       <= db_nxt;
    kc_r       <= kc_nxt;
    res_node_r <= res_node_nxt;
    res_dist_r <= res_dist_nxt;
    res_flag_r <= res_flag_nxt;
    out_r      <= out_nxt;
  end

endmodule

### src/tree_ancestor_query_engine.sv
// binary-lifting tree engine: load nodes (parent first), then ask for the
// lowest common ancestor, k-th ancestor, path distance or k-th path node.
// in_valid/in_stall/in_data carry one command per transaction, and
// out_valid/out_stall/out_data return exactly one result per command.
// each node owns one memory row (depth plus ancestor chain), read on two
// registered ports; one dependent row read per cycle sets the pace.
// load: one row read per chain level, then the row write.
// k-th ancestor: one row read per bit of k.
// ancestor/distance: two walks over all levels, only the first when the
// first walk already lands on the other node.
// path node: both walks plus a climb.
// after reset the memory is swept to zero, one row per cycle, all 1024 rows,
// with in_stall high.
// the result waits in an output register; a new command is taken while it
// waits, and the finished next result holds until out_stall drops.
module tree_ancestor_query_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  taqe_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output taqe_pkg::out_item_t out_data
);
  import taqe_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  taqe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .stat      (dp_stat),
    .cmd       (ctrl_cmd)
  );

  taqe_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .out_data (out_data),
    .cmd      (ctrl_cmd),
    .stat     (dp_stat)
  );

  // one transaction at a time in the engine
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second transaction accepted while busy");

  a_write_only_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl_cmd.op == OP_LD_WRITE) |-> (dp_stat.cmd == CMD_LOAD && dp_stat.load_ok))
    else $error("row written outside a valid load");

  a_emit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl_cmd.op == OP_EMIT) |=> out_valid)
    else $error("emitted result not presented");

endmodule

### dv/tree_ancestor_query_engine_tb.sv
module tree_ancestor_query_engine_tb;
  import taqe_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  tree_ancestor_query_engine DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // predictor state
  logic [NODE_W-1:0]  anc_mem [0:MAX_NODES][0:LEVELS-1];
  logic [DEPTH_W-1:0] dep_mem [0:MAX_NODES];

  out_item_t expected_q[$];
  int        mismatches = 0;
  int        send_idle_pct;
  int        recv_idle_pct;
  int        loaded_q[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int node_depth(int n);
    if (n > MAX_NODES) return 0;
    return int'(dep_mem[n]);
  endfunction

  function automatic int lift(int n, int lv);
    if (n > MAX_NODES || lv >= LEVELS) return 0;
    return int'(anc_mem[n][lv]);
  endfunction

  function automatic int climb_up(int n, int k);
    if (k < 0 || k > node_depth(n)) return 0;
    for (int i = 0; i < LEVELS; i++)
      if ((k >> i) & 1) n = lift(n, i);
    return n;
  endfunction

  function automatic int common_anc(int u, int v);
    int t;
    int a;
    int b;
    if (node_depth(u) < node_depth(v)) begin
      t = u; u = v; v = t;
    end
    for (int lv = LEVELS - 1; lv >= 0; lv--) begin
      a = lift(u, lv);
      if (node_depth(a) >= node_depth(v)) u = a;
    end
    if (u == v) return v;
    for (int lv = LEVELS - 1; lv >= 0; lv--) begin
      a = lift(u, lv);
      b = lift(v, lv);
      if (a != b) begin
        u = a; v = b;
      end
    end
    return lift(u, 0);
  endfunction

  function automatic out_item_t predict_answer(in_item_t it);
    out_item_t r;
    int a;
    int b;
    int k;
    int l;
    int d;
    int rest;
    r = '0;
    a = (it.node_a > MAX_NODES) ? 0 : int'(it.node_a);
    b = (it.node_b > MAX_NODES) ? 0 : int'(it.node_b);
    k = int'(it.step_count);
    case (it.cmd)
      CMD_LOAD: begin
        r.result_node = it.node_a;
        if (a != 0 && it.node_b <= MAX_NODES) begin
          d = node_depth(b) + 1;
          if (d > MAX_NODES) d = MAX_NODES;
          dep_mem[a] = DEPTH_W'(d);
          anc_mem[a][0] = NODE_W'(b);
          for (int i = 1; i < LEVELS; i++)
            anc_mem[a][i] = NODE_W'(lift(lift(a, i - 1), i - 1));
        end
      end
      CMD_LCA: r.result_node = NODE_W'(common_anc(a, b));
      CMD_KTH: r.result_node = NODE_W'(climb_up(a, k));
      CMD_DIST, CMD_PATH: begin
        l = common_anc(a, b);
        d = node_depth(a) + node_depth(b) - 2 * node_depth(l);
        if (d < 0) d = 0;
        if (d > 2047) d = 2047;
        if (it.cmd == CMD_DIST) r.result_distance = DIST_W'(d);
        else if (k >= d) r.step_out_of_range = 1'b1;
        else if (node_depth(l) + k <= node_depth(a))
          r.result_node = NODE_W'(climb_up(a, k));
        else begin
          rest = k - (node_depth(a) - node_depth(l));
          r.result_node = NODE_W'(climb_up(b, node_depth(b) - node_depth(l) - rest));
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic send_cmd(input logic [CMD_W-1:0] c, input int a, input int b, input int k);
    in_item_t it;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    it.cmd = c;
    it.node_a = NODE_W'(a);
    it.node_b = NODE_W'(b);
    it.step_count = STEP_W'(k);
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.insert(expected_q.size(), predict_answer(it));
    if (c == CMD_LOAD && a != 0 && a <= MAX_NODES && b <= MAX_NODES)
      loaded_q.insert(loaded_q.size(), a);
    @(negedge clk);
  endtask

  // receiver stall
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data);
      end else begin
        e = expected_q.pop_front();
        if (out_data.result_node !== e.result_node ||
            out_data.result_distance !== e.result_distance ||
            out_data.step_out_of_range !== e.step_out_of_range) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp node %0d dist %0d flag %0d, got node %0d dist %0d flag %0d",
                     e.result_node, e.result_distance, e.step_out_of_range,
                     out_data.result_node, out_data.result_distance,
                     out_data.step_out_of_range);
        end
      end
    end
  end

  function automatic int pick_node();
    if (loaded_q.size() == 0 || $urandom_range(9) == 0) return $urandom_range(1023);
    return loaded_q[$urandom_range(loaded_q.size() - 1)];
  endfunction

  task automatic test_directed();
    // chain 1..4, node 5 branching off 2, plus special cases
    send_cmd(CMD_LOAD, 1, 0, 0);
    send_cmd(CMD_LOAD, 2, 1, 1023);
    send_cmd(CMD_LOAD, 3, 2, 0);
    send_cmd(CMD_LOAD, 4, 3, 0);
    send_cmd(CMD_LOAD, 5, 2, 0);
    send_cmd(CMD_LOAD, 0, 1, 0);
    send_cmd(CMD_LOAD, 1023, 1023, 0);
    send_cmd(CMD_LOAD, 1023, 5, 0);
    send_cmd(CMD_LCA, 4, 5, 0);
    send_cmd(CMD_LCA, 4, 4, 0);
    send_cmd(CMD_LCA, 0, 1023, 0);
    send_cmd(CMD_KTH, 4, 0, 2);
    send_cmd(CMD_KTH, 4, 0, 1023);
    send_cmd(CMD_KTH, 4, 0, 3);
    send_cmd(CMD_DIST, 4, 5, 0);
    send_cmd(CMD_DIST, 900, 4, 0);
    send_cmd(CMD_PATH, 4, 5, 0);
    send_cmd(CMD_PATH, 4, 5, 2);
    send_cmd(CMD_PATH, 4, 5, 3);
    send_cmd(CMD_PATH, 4, 5, 1023);
    send_cmd(3'd5, 1023, 1023, 1023);
    send_cmd(3'd7, 4, 5, 1);
    send_cmd(CMD_LOAD, 3, 5, 0);
    send_cmd(CMD_PATH, 4, 1023, 1);
  endtask

  task automatic test_random(input int n);
    int r;
    int a;
    int b;
    int d;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      a = pick_node();
      b = pick_node();
      if (r < 25) begin
        // a parent mostly already loaded keeps trees deep; the node id is usually nonzero
        send_cmd(CMD_LOAD, ($urandom_range(19) == 0) ? $urandom_range(1023)
                 : $urandom_range(1, 1023), ($urandom_range(15) == 0) ? 0 : b, $urandom_range(1023));
      end else if (r < 40) send_cmd(CMD_LCA, a, b, $urandom_range(1023));
      else if (r < 58) begin
        d = node_depth(a);
        send_cmd(CMD_KTH, a, b, ($urandom_range(7) == 0) ? $urandom_range(1023)
                 : $urandom_range(d + 1));
      end else if (r < 72) send_cmd(CMD_DIST, a, b, $urandom_range(1023));
      else if (r < 97) begin
        d = node_depth(a) + node_depth(b);
        send_cmd(CMD_PATH, a, b, ($urandom_range(7) == 0) ? $urandom_range(1023)
                 : $urandom_range(d + 1));
      end else send_cmd(CMD_W'($urandom_range(5, 7)), a, b, $urandom_range(1023));
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int n = 0; n <= MAX_NODES; n++) begin
      dep_mem[n] = '0;
      for (int l = 0; l < LEVELS; l++) anc_mem[n][l] = '0;
    end
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 8;
    recv_idle_pct = 85;
    test_directed();
    test_random(600);
    send_idle_pct = 85;
    recv_idle_pct = 8;
    test_random(600);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(630);
    drain();
    if (mismatches == 0 && expected_q.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
